// ----- sv/mskf_pkg.sv -----
// ----------------------------------------------------------------------------
// mskf_pkg: shared definitions for the scalar Kalman filter bank
// Field widths, fixed-point constants, register indexes, sequencer states
// and the per-channel state record.
// ----------------------------------------------------------------------------
package mskf_pkg;

    // Field widths
    localparam int IN_CH_W    = 8;
    localparam int SAMPLE_W   = 16;
    localparam int EST_W      = 33;   // estimate, signed Q16.16 with one guard bit
    localparam int ERR_W      = 32;   // error estimate, unsigned Q16.16
    localparam int SPEED_W    = 20;   // process speed, unsigned Q4.16
    localparam int GAIN_W     = 16;   // gain, Q0.16
    localparam int FRAC_W     = 16;
    localparam int DIFF_W     = 34;   // sample minus estimate, signed
    localparam int AD_W       = 33;   // magnitude of the estimate change
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Shared multiplier: the wide operand is split into 17-bit slices
    localparam int SPLIT      = 17;
    localparam int MUL_A_W    = 18;
    localparam int MUL_B_W    = 21;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = PROD_W + SPLIT;

    localparam int DIV_CNT_W  = $clog2(GAIN_W);

    // Constants
    localparam logic [ERR_W-1:0]   ERR_INIT    = 32'd2621440;   // 40.0
    localparam logic [ERR_W-1:0]   MEAS_RESET  = 32'd65536;     // 1.0
    localparam logic [SPEED_W-1:0] SPEED_RESET = 20'd655;
    localparam logic [GAIN_W:0]    ONE_Q16     = 17'h10000;
    localparam logic [FRAC_W-1:0]  HALF_Q16    = 16'h8000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_ERR   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_SPEED = 4'd1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_ACC,
        ST_POST,
        ST_FINAL
    } state_t;

    typedef enum logic [1:0] {
        PH_GAIN,
        PH_DECAY,
        PH_SPEED
    } mul_phase_t;

    typedef struct packed {
        logic signed [EST_W-1:0] est;
        logic [ERR_W-1:0]        err;
    } chan_state_t;

endpackage

// ----- sv/mskf_state_mem.sv -----
// ----------------------------------------------------------------------------
// mskf_state_mem: per-channel filter state
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mskf_state_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  mskf_pkg::chan_state_t wdata,
    input  logic [AW-1:0]        raddr,
    output mskf_pkg::chan_state_t rdata
);

    mskf_pkg::chan_state_t mem [DEPTH];
    mskf_pkg::chan_state_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/mskf_div.sv -----
// ----------------------------------------------------------------------------
// mskf_div: gain divider
// Restoring division p * 2^16 / (p + r), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mskf_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mskf_pkg::ERR_W-1:0]     p,
    input  logic [mskf_pkg::ERR_W-1:0]     r,
    output logic                           done,
    output logic [mskf_pkg::GAIN_W-1:0]    quot
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [mskf_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [mskf_pkg::ERR_W:0]          den_reg, den_next;
    logic [mskf_pkg::ERR_W:0]          rem_reg, rem_next;
    logic [mskf_pkg::GAIN_W-1:0]       quot_reg, quot_next;
    logic [mskf_pkg::ERR_W+1:0]        rem2;
    logic [mskf_pkg::ERR_W+1:0]        rem_sub;
    logic                              ge;

    always_comb
    begin
        rem2      = {rem_reg, 1'b0};
        rem_sub   = rem2 - {1'b0, den_reg};
        ge        = (rem2 >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        priority if (start)
        begin
            if (r == '0)
            begin
                // zero measurement error: gain pins just under one, or zero
                busy_next = 1'b0;
                done_next = 1'b1;
                quot_next = (p == '0) ? '0 : '1;
            end
            else
            begin
                den_next  = {1'b0, p} + {1'b0, r};
                rem_next  = {1'b0, p};
                quot_next = '0;
                cnt_next  = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? rem_sub[mskf_pkg::ERR_W:0] : rem2[mskf_pkg::ERR_W:0];
            quot_next = {quot_reg[mskf_pkg::GAIN_W-2:0], ge};
            cnt_next  = cnt_reg + mskf_pkg::DIV_CNT_W'(1);
            if (cnt_reg == mskf_pkg::DIV_CNT_W'(mskf_pkg::GAIN_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else
        begin
            // idle: hold the last quotient
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- sv/mskf_mul.sv -----
// ----------------------------------------------------------------------------
// mskf_mul: shared signed multiplier
// One registered 18 x 21 signed product per cycle.
// ----------------------------------------------------------------------------
module mskf_mul (
    input  logic                                clk,
    input  logic signed [mskf_pkg::MUL_A_W-1:0] a,
    input  logic signed [mskf_pkg::MUL_B_W-1:0] b,
    output logic signed [mskf_pkg::PROD_W-1:0]  prod
);

    logic signed [mskf_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ----- sv/multichannel_scalar_kalman_filter.sv -----
// Flow: an input transfer is taken only while idle, so one item is worked on at a time;
//   a result stall holds the item in the final step. Each update runs the 16-step gain
//   divider (which gives its quotient without the steps when measurement_error is zero)
//   and three two-slice passes through the shared multiplier; an out-of-range channel skips both.
// Reset: asynchronous, active low; then a clearing pass over all CHANNELS entries
//   loads every channel's state before the first input transfer.
// ----------------------------------------------------------------------------
// multichannel_scalar_kalman_filter: bank of scalar Kalman filters
// Per-channel estimate and error estimate in one state memory; a sequencer
// drives a shared divider and a shared multiplier through each update.
// ----------------------------------------------------------------------------
module multichannel_scalar_kalman_filter #(
    parameter int CHANNELS = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [mskf_pkg::IN_CH_W-1:0]       channel,
    input  logic signed [mskf_pkg::SAMPLE_W-1:0] sample,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mskf_pkg::IN_CH_W-1:0]       channel_out,
    output logic signed [mskf_pkg::SAMPLE_W-1:0] estimate,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mskf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mskf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_CMP_W = ((IDX_W > mskf_pkg::IN_CH_W) ? IDX_W : mskf_pkg::IN_CH_W) + 1;
    localparam int ESUM_W   = mskf_pkg::ACC_W - mskf_pkg::FRAC_W + 1;   // 41
    localparam int RND_W    = mskf_pkg::EST_W + 1;                      // 34
    localparam int PSUM_W   = mskf_pkg::ACC_W - mskf_pkg::FRAC_W - 1;   // 39
    localparam int PA_W     = mskf_pkg::ERR_W + 1;                      // 33
    localparam int PB_W     = PSUM_W - 1;                               // 38

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    mskf_pkg::state_t     state_reg, state_next;
    mskf_pkg::mul_phase_t phase_reg, phase_next;
    logic [IDX_W-1:0]     clr_addr_reg, clr_addr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [mskf_pkg::ERR_W-1:0]   meas_err_reg, meas_err_next;
    logic [mskf_pkg::SPEED_W-1:0] speed_reg, speed_next;

    logic [IDX_W-1:0]                    idx_reg, idx_next;
    logic [mskf_pkg::IN_CH_W-1:0]        channel_reg, channel_next;
    logic signed [mskf_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    logic                                oor_reg, oor_next;
    logic signed [mskf_pkg::EST_W-1:0]   e_reg, e_next;
    logic [mskf_pkg::ERR_W-1:0]          p_reg, p_next;
    logic signed [mskf_pkg::DIFF_W-1:0]  diff_reg, diff_next;
    logic [mskf_pkg::GAIN_W-1:0]         k_reg, k_next;
    logic [mskf_pkg::GAIN_W:0]           omk_reg, omk_next;
    logic signed [mskf_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic signed [mskf_pkg::EST_W-1:0]   e_new_reg, e_new_next;
    logic [PA_W-1:0]                     pa_reg, pa_next;
    logic [mskf_pkg::AD_W-1:0]           ad_reg, ad_next;
    logic [PB_W-1:0]                     pb_reg, pb_next;
    logic [mskf_pkg::IN_CH_W-1:0]        channel_out_reg, channel_out_next;
    logic signed [mskf_pkg::SAMPLE_W-1:0] estimate_reg, estimate_next;

    // ------------------------------------------------------------------------
    // Shared units and memory hookup
    // ------------------------------------------------------------------------
    logic                                 div_start;
    logic                                 div_done;
    logic [mskf_pkg::GAIN_W-1:0]          div_quot;
    logic signed [mskf_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [mskf_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [mskf_pkg::PROD_W-1:0]   mul_prod;
    logic                                 mem_we;
    logic [IDX_W-1:0]                     mem_waddr;
    mskf_pkg::chan_state_t                mem_wdata;
    mskf_pkg::chan_state_t                mem_rdata;

    // ------------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------------
    logic                                 in_range;
    logic                                 in_fire;
    logic                                 out_free;
    logic signed [mskf_pkg::ACC_W-1:0]    prod_ext;
    logic signed [mskf_pkg::ACC_W-1:0]    acc_round;
    logic signed [ESUM_W-1:0]             e_sum;
    logic signed [mskf_pkg::EST_W-1:0]    e_clamped;
    logic signed [RND_W-1:0]              delta;
    logic [PSUM_W-1:0]                    p_sum;
    logic [mskf_pkg::ERR_W-1:0]           p_new;
    logic signed [RND_W-1:0]              r_sum;
    logic signed [RND_W-mskf_pkg::FRAC_W-1:0] r_int;
    logic signed [mskf_pkg::SAMPLE_W-1:0] r_sat;

    assign in_range  = ({1'b0, (CH_CMP_W-1)'(channel)} < (CH_CMP_W)'(CHANNELS));
    assign in_ready  = (state_reg == mskf_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    mskf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .p     (mem_rdata.err),
        .r     (meas_err_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    mskf_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    mskf_state_mem #(
        .DEPTH (CHANNELS),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    // Operand select: low slice in MUL_LO, high slice in MUL_HI
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (phase_reg)
            mskf_pkg::PH_GAIN:
            begin
                mul_b = {5'b0, k_reg};
                if (state_reg == mskf_pkg::ST_MUL_HI)
                    mul_a = {diff_reg[mskf_pkg::DIFF_W-1], diff_reg[mskf_pkg::DIFF_W-1:17]};
                else
                    mul_a = {1'b0, diff_reg[16:0]};
            end
            mskf_pkg::PH_DECAY:
            begin
                mul_b = {4'b0, omk_reg};
                if (state_reg == mskf_pkg::ST_MUL_HI)
                    mul_a = {3'b0, p_reg[mskf_pkg::ERR_W-1:17]};
                else
                    mul_a = {1'b0, p_reg[16:0]};
            end
            mskf_pkg::PH_SPEED:
            begin
                mul_b = {1'b0, speed_reg};
                if (state_reg == mskf_pkg::ST_MUL_HI)
                    mul_a = {2'b0, ad_reg[mskf_pkg::AD_W-1:17]};
                else
                    mul_a = {1'b0, ad_reg[16:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rounding and saturation arithmetic
    always_comb
    begin
        prod_ext  = {{(mskf_pkg::ACC_W-mskf_pkg::PROD_W){mul_prod[mskf_pkg::PROD_W-1]}},
                     mul_prod};
        acc_round = acc_reg + mskf_pkg::ACC_W'(mskf_pkg::HALF_Q16);

        // estimate step: floor of rounded product, then clamp to 33 bits
        e_sum = {{(ESUM_W-mskf_pkg::EST_W){e_reg[mskf_pkg::EST_W-1]}}, e_reg}
              + {acc_round[mskf_pkg::ACC_W-1], acc_round[mskf_pkg::ACC_W-1:mskf_pkg::FRAC_W]};
        if (e_sum[ESUM_W-1:mskf_pkg::EST_W-1] == '0 || e_sum[ESUM_W-1:mskf_pkg::EST_W-1] == '1)
            e_clamped = e_sum[mskf_pkg::EST_W-1:0];
        else if (e_sum[ESUM_W-1])
            e_clamped = {1'b1, {(mskf_pkg::EST_W-1){1'b0}}};
        else
            e_clamped = {1'b0, {(mskf_pkg::EST_W-1){1'b1}}};

        delta = {e_new_reg[mskf_pkg::EST_W-1], e_new_reg} - {e_reg[mskf_pkg::EST_W-1], e_reg};

        // new error estimate, saturated
        p_sum = PSUM_W'(pa_reg) + PSUM_W'(pb_reg);
        if (p_sum[PSUM_W-1:mskf_pkg::ERR_W] != '0)
            p_new = '1;
        else
            p_new = p_sum[mskf_pkg::ERR_W-1:0];

        // round half away from zero: add one half, one less for negatives
        r_sum = {e_new_reg[mskf_pkg::EST_W-1], e_new_reg}
              + RND_W'(mskf_pkg::HALF_Q16)
              - RND_W'(e_new_reg[mskf_pkg::EST_W-1]);
        r_int = r_sum[RND_W-1:mskf_pkg::FRAC_W];
        if (r_int[RND_W-mskf_pkg::FRAC_W-1:mskf_pkg::SAMPLE_W-1] == '0 ||
            r_int[RND_W-mskf_pkg::FRAC_W-1:mskf_pkg::SAMPLE_W-1] == '1)
            r_sat = r_int[mskf_pkg::SAMPLE_W-1:0];
        else if (r_int[RND_W-mskf_pkg::FRAC_W-1])
            r_sat = {1'b1, {(mskf_pkg::SAMPLE_W-1){1'b0}}};
        else
            r_sat = {1'b0, {(mskf_pkg::SAMPLE_W-1){1'b1}}};
    end

    // ------------------------------------------------------------------------
    // Sequencer: next state and datapath register updates
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        clr_addr_next    = clr_addr_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        meas_err_next    = meas_err_reg;
        speed_next       = speed_reg;
        idx_next         = idx_reg;
        channel_next     = channel_reg;
        sample_next      = sample_reg;
        oor_next         = oor_reg;
        e_next           = e_reg;
        p_next           = p_reg;
        diff_next        = diff_reg;
        k_next           = k_reg;
        omk_next         = omk_reg;
        acc_next         = acc_reg;
        e_new_next       = e_new_reg;
        pa_next          = pa_reg;
        ad_next          = ad_reg;
        pb_next          = pb_reg;
        channel_out_next = channel_out_reg;
        estimate_next    = estimate_reg;
        div_start        = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = idx_reg;
        mem_wdata.est    = e_new_reg;
        mem_wdata.err    = p_new;

        // register writes land whenever the write channel transfers
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == mskf_pkg::REG_MEAS_ERR)
                meas_err_next = cfg_data;
            else if (cfg_index == mskf_pkg::REG_PROC_SPEED)
                speed_next = cfg_data[mskf_pkg::SPEED_W-1:0];
        end

        unique case (state_reg)
            mskf_pkg::ST_CLEAR:
            begin
                // sweep every channel to its initial state
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata.est = '0;
                mem_wdata.err = mskf_pkg::ERR_INIT;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == IDX_W'(CHANNELS - 1))
                    state_next = mskf_pkg::ST_IDLE;
            end
            mskf_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    channel_next = channel;
                    sample_next  = sample;
                    idx_next     = IDX_W'(channel);
                    oor_next     = !in_range;
                    state_next   = in_range ? mskf_pkg::ST_READ : mskf_pkg::ST_FINAL;
                end
            end
            mskf_pkg::ST_READ:
            begin
                // memory read of the channel's state is in flight
                state_next = mskf_pkg::ST_LOAD;
            end
            mskf_pkg::ST_LOAD:
            begin
                e_next     = mem_rdata.est;
                p_next     = mem_rdata.err;
                diff_next  = {{2{sample_reg[mskf_pkg::SAMPLE_W-1]}}, sample_reg,
                              {mskf_pkg::FRAC_W{1'b0}}}
                           - {mem_rdata.est[mskf_pkg::EST_W-1], mem_rdata.est};
                div_start  = 1'b1;
                state_next = mskf_pkg::ST_DIV;
            end
            mskf_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    k_next     = div_quot;
                    omk_next   = mskf_pkg::ONE_Q16 - {1'b0, div_quot};
                    phase_next = mskf_pkg::PH_GAIN;
                    state_next = mskf_pkg::ST_MUL_LO;
                end
            end
            mskf_pkg::ST_MUL_LO:
            begin
                state_next = mskf_pkg::ST_MUL_HI;
            end
            mskf_pkg::ST_MUL_HI:
            begin
                acc_next   = prod_ext;
                state_next = mskf_pkg::ST_MUL_ACC;
            end
            mskf_pkg::ST_MUL_ACC:
            begin
                acc_next   = acc_reg + (prod_ext <<< mskf_pkg::SPLIT);
                state_next = mskf_pkg::ST_POST;
            end
            mskf_pkg::ST_POST:
            begin
                unique case (phase_reg)
                    mskf_pkg::PH_GAIN:
                    begin
                        e_new_next = e_clamped;
                        phase_next = mskf_pkg::PH_DECAY;
                        state_next = mskf_pkg::ST_MUL_LO;
                    end
                    mskf_pkg::PH_DECAY:
                    begin
                        pa_next    = acc_round[mskf_pkg::FRAC_W+PA_W-1:mskf_pkg::FRAC_W];
                        ad_next    = delta[RND_W-1] ? mskf_pkg::AD_W'(-delta)
                                                    : mskf_pkg::AD_W'(delta);
                        phase_next = mskf_pkg::PH_SPEED;
                        state_next = mskf_pkg::ST_MUL_LO;
                    end
                    mskf_pkg::PH_SPEED:
                    begin
                        pb_next    = acc_round[mskf_pkg::FRAC_W+PB_W-1:mskf_pkg::FRAC_W];
                        state_next = mskf_pkg::ST_FINAL;
                    end
                    default:
                    begin
                        state_next = mskf_pkg::ST_IDLE;
                    end
                endcase
            end
            mskf_pkg::ST_FINAL:
            begin
                // hold until the result register is free, then write back (in-range channels only)
                if (out_free)
                begin
                    mem_we           = !oor_reg;
                    out_valid_next   = 1'b1;
                    channel_out_next = channel_reg;
                    estimate_next    = oor_reg ? '0 : r_sat;
                    state_next       = mskf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mskf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mskf_pkg::ST_CLEAR;
            phase_reg     <= mskf_pkg::PH_GAIN;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            meas_err_reg  <= mskf_pkg::MEAS_RESET;
            speed_reg     <= mskf_pkg::SPEED_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            meas_err_reg  <= meas_err_next;
            speed_reg     <= speed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        channel_reg     <= channel_next;
        sample_reg      <= sample_next;
        oor_reg         <= oor_next;
        e_reg           <= e_next;
        p_reg           <= p_next;
        diff_reg        <= diff_next;
        k_reg           <= k_next;
        omk_reg         <= omk_next;
        acc_reg         <= acc_next;
        e_new_reg       <= e_new_next;
        pa_reg          <= pa_next;
        ad_reg          <= ad_next;
        pb_reg          <= pb_next;
        channel_out_reg <= channel_out_next;
        estimate_reg    <= estimate_next;
    end

    assign out_valid   = out_valid_reg;
    assign channel_out = channel_out_reg;
    assign estimate    = estimate_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_drops_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input still ready after a transfer");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == mskf_pkg::ST_DIV))
        else $error("divider finished outside the divide step");

    a_result_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == mskf_pkg::ST_FINAL))
        else $error("result raised outside the final step");

    a_oor_skips_math: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mskf_pkg::ST_MUL_LO && phase_reg == mskf_pkg::PH_GAIN) |-> !oor_reg)
        else $error("out-of-range channel entered the update");

endmodule
